/* rtl/oas_pkg.sv */
// ----------------------------------------------------------------------------
// oas_pkg
// Shared types, codes and constants of the obstacle avoidance sequencer.
// ----------------------------------------------------------------------------
package oas_pkg;

   // field widths
   localparam int DIST_W   = 12;
   localparam int SPEED_W  = 10;
   localparam int TURN_W   = 9;
   localparam int CMD_W    = 3;
   localparam int LEVEL_W  = 10;
   localparam int MODE_W   = 3;
   localparam int TICK_W   = 8;
   localparam int TOTAL_W  = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [TICK_W-1:0] CHECK_TICKS = 8'd3;

   localparam logic [LEVEL_W-1:0] WHEEL_MIN = 10'd50;
   localparam logic [LEVEL_W-1:0] WHEEL_MAX = 10'd600;

   // motor commands
   localparam logic [CMD_W-1:0] CMD_STOP       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FORWARD    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SPIN_LEFT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SPIN_RIGHT = 3'd5;

   // mode numbers as reported on the result word
   localparam logic [MODE_W-1:0] MODE_NUM_LINE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NUM_STOP    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_NUM_SPIN_L  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_NUM_CHECK_L = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NUM_SPIN_R  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_NUM_CHECK_R = 3'd5;
   localparam logic [MODE_W-1:0] MODE_NUM_BYPASS  = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPIN_PWM         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BYPASS_PWM       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_TICKS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_QUARTER_TICKS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_TICKS       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BYPASS_TICKS     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS    = 3'd7;

   typedef enum logic [6:0] {
      MODE_LINE    = 7'b0000001,
      MODE_STOP    = 7'b0000010,
      MODE_SPIN_L  = 7'b0000100,
      MODE_CHECK_L = 7'b0001000,
      MODE_SPIN_R  = 7'b0010000,
      MODE_CHECK_R = 7'b0100000,
      MODE_BYPASS  = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [DIST_W-1:0]  detect_threshold_mm;
      logic [LEVEL_W-1:0] spin_pwm;
      logic [LEVEL_W-1:0] bypass_pwm;
      logic [TICK_W-1:0]  stop_ticks;
      logic [TICK_W-1:0]  quarter_turn_ticks;
      logic [TICK_W-1:0]  half_turn_ticks;
      logic [TICK_W-1:0]  bypass_ticks;
      logic [TOTAL_W-1:0] timeout_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      detect_threshold_mm: 12'd200,
      spin_pwm:            10'd700,
      bypass_pwm:          10'd250,
      stop_ticks:          8'd7,
      quarter_turn_ticks:  8'd27,
      half_turn_ticks:     8'd53,
      bypass_ticks:        8'd33,
      timeout_ticks:       9'd333
   };

   typedef struct packed {
      mode_type           mode;
      logic [TICK_W-1:0]  mode_ticks;
      logic [TOTAL_W-1:0] total_ticks;
      logic [CMD_W-1:0]   held_command;
      logic [LEVEL_W-1:0] held_drive;
      logic [LEVEL_W-1:0] held_left;
      logic [LEVEL_W-1:0] held_right;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:         MODE_LINE,
      mode_ticks:   '0,
      total_ticks:  '0,
      held_command: CMD_STOP,
      held_drive:   '0,
      held_left:    '0,
      held_right:   '0
   };

   typedef struct packed {
      logic regulator_used;
      logic regulator_reset;
   } flags_type;

   function automatic logic [MODE_W-1:0] mode_number(mode_type m);
      logic [MODE_W-1:0] n;
      case (m)
         MODE_LINE:    n = MODE_NUM_LINE;
         MODE_STOP:    n = MODE_NUM_STOP;
         MODE_SPIN_L:  n = MODE_NUM_SPIN_L;
         MODE_CHECK_L: n = MODE_NUM_CHECK_L;
         MODE_SPIN_R:  n = MODE_NUM_SPIN_R;
         MODE_CHECK_R: n = MODE_NUM_CHECK_R;
         MODE_BYPASS:  n = MODE_NUM_BYPASS;
         default:      n = MODE_NUM_LINE;
      endcase
      return n;
   endfunction

endpackage

/* rtl/oas_step.sv */
// ----------------------------------------------------------------------------
// oas_step
// Next-state logic for one control tick: timeout, mode sequence and wheel mix.
// ----------------------------------------------------------------------------
module oas_step (
   input  oas_pkg::cfg_type                 cfg,
   input  oas_pkg::state_type               cur,
   input  logic [oas_pkg::DIST_W-1:0]       distance_mm,
   input  logic [oas_pkg::SPEED_W-1:0]      speed_correction,
   input  logic signed [oas_pkg::TURN_W-1:0] turn_correction,
   output oas_pkg::state_type               nxt,
   output oas_pkg::flags_type               flags
);

   logic                                seen;
   logic                                clear;
   logic [oas_pkg::TOTAL_W:0]           total_inc;
   logic [oas_pkg::TICK_W:0]            tick_inc;
   logic [oas_pkg::SPEED_W-1:0]         base;
   logic signed [11:0]                  left_sum;
   logic signed [11:0]                  right_sum;
   logic [oas_pkg::LEVEL_W-1:0]         left_wheel;
   logic [oas_pkg::LEVEL_W-1:0]         right_wheel;
   oas_pkg::mode_type                   mode;

   assign seen  = (distance_mm != '0) && (distance_mm <= cfg.detect_threshold_mm);
   assign clear = distance_mm > cfg.detect_threshold_mm;

   assign total_inc = {1'b0, cur.total_ticks} + 10'd1;
   assign tick_inc  = {1'b0, cur.mode_ticks} + 9'd1;

   // wheel mix: base floored at the wheel minimum, then each wheel clamped
   assign base      = (speed_correction < oas_pkg::WHEEL_MIN) ? oas_pkg::WHEEL_MIN
                                                              : speed_correction;
   assign left_sum  = $signed({2'b00, base}) + 12'(turn_correction);
   assign right_sum = $signed({2'b00, base}) - 12'(turn_correction);

   always_comb begin
      if (left_sum < $signed({2'b00, oas_pkg::WHEEL_MIN}))
         left_wheel = oas_pkg::WHEEL_MIN;
      else if (left_sum > $signed({2'b00, oas_pkg::WHEEL_MAX}))
         left_wheel = oas_pkg::WHEEL_MAX;
      else
         left_wheel = left_sum[oas_pkg::LEVEL_W-1:0];
      if (right_sum < $signed({2'b00, oas_pkg::WHEEL_MIN}))
         right_wheel = oas_pkg::WHEEL_MIN;
      else if (right_sum > $signed({2'b00, oas_pkg::WHEEL_MAX}))
         right_wheel = oas_pkg::WHEEL_MAX;
      else
         right_wheel = right_sum[oas_pkg::LEVEL_W-1:0];
   end

   always_comb begin
      nxt   = cur;
      flags = '0;
      mode  = cur.mode;

      // overall timeout drops back to line follow, which then runs this tick
      if (cur.mode != oas_pkg::MODE_LINE) begin
         nxt.total_ticks = total_inc[oas_pkg::TOTAL_W-1:0];
         if (total_inc >= {1'b0, cfg.timeout_ticks}) begin
            mode                  = oas_pkg::MODE_LINE;
            nxt.mode_ticks        = '0;
            nxt.total_ticks       = '0;
            flags.regulator_reset = 1'b1;
            nxt.held_command      = oas_pkg::CMD_STOP;
            nxt.held_drive        = '0;
         end
      end

      case (mode)
         oas_pkg::MODE_LINE: begin
            nxt.total_ticks = '0;
            if (seen) begin
               mode                  = oas_pkg::MODE_STOP;
               nxt.mode_ticks        = '0;
               flags.regulator_reset = 1'b1;
               nxt.held_command      = oas_pkg::CMD_STOP;
               nxt.held_drive        = '0;
               nxt.held_left         = '0;
               nxt.held_right        = '0;
            end else begin
               nxt.held_left        = left_wheel;
               nxt.held_right       = right_wheel;
               nxt.held_command     = oas_pkg::CMD_FORWARD;
               flags.regulator_used = 1'b1;
            end
         end
         oas_pkg::MODE_STOP: begin
            nxt.held_command = oas_pkg::CMD_STOP;
            nxt.held_drive   = '0;
            nxt.mode_ticks   = tick_inc[oas_pkg::TICK_W-1:0];
            if (tick_inc >= {1'b0, cfg.stop_ticks}) begin
               mode           = oas_pkg::MODE_SPIN_L;
               nxt.mode_ticks = '0;
            end
         end
         oas_pkg::MODE_SPIN_L: begin
            nxt.held_command = oas_pkg::CMD_SPIN_LEFT;
            nxt.held_drive   = cfg.spin_pwm;
            nxt.mode_ticks   = tick_inc[oas_pkg::TICK_W-1:0];
            if (tick_inc >= {1'b0, cfg.quarter_turn_ticks}) begin
               mode             = oas_pkg::MODE_CHECK_L;
               nxt.mode_ticks   = '0;
               nxt.held_command = oas_pkg::CMD_STOP;
               nxt.held_drive   = '0;
            end
         end
         oas_pkg::MODE_CHECK_L: begin
            nxt.held_command = oas_pkg::CMD_STOP;
            nxt.held_drive   = '0;
            nxt.mode_ticks   = tick_inc[oas_pkg::TICK_W-1:0];
            if (tick_inc >= {1'b0, oas_pkg::CHECK_TICKS}) begin
               mode           = clear ? oas_pkg::MODE_BYPASS : oas_pkg::MODE_SPIN_R;
               nxt.mode_ticks = '0;
            end
         end
         oas_pkg::MODE_SPIN_R: begin
            nxt.held_command = oas_pkg::CMD_SPIN_RIGHT;
            nxt.held_drive   = cfg.spin_pwm;
            nxt.mode_ticks   = tick_inc[oas_pkg::TICK_W-1:0];
            if (tick_inc >= {1'b0, cfg.half_turn_ticks}) begin
               mode             = oas_pkg::MODE_CHECK_R;
               nxt.mode_ticks   = '0;
               nxt.held_command = oas_pkg::CMD_STOP;
               nxt.held_drive   = '0;
            end
         end
         oas_pkg::MODE_CHECK_R: begin
            nxt.held_command = oas_pkg::CMD_STOP;
            nxt.held_drive   = '0;
            nxt.mode_ticks   = tick_inc[oas_pkg::TICK_W-1:0];
            // dead end goes back to line follow with no regulator clear
            if (tick_inc >= {1'b0, oas_pkg::CHECK_TICKS}) begin
               mode           = clear ? oas_pkg::MODE_BYPASS : oas_pkg::MODE_LINE;
               nxt.mode_ticks = '0;
            end
         end
         oas_pkg::MODE_BYPASS: begin
            nxt.held_command = oas_pkg::CMD_FORWARD;
            nxt.held_drive   = cfg.bypass_pwm;
            if (seen) begin
               mode           = oas_pkg::MODE_STOP;
               nxt.mode_ticks = '0;
            end else if (tick_inc >= {1'b0, cfg.bypass_ticks}) begin
               mode                  = oas_pkg::MODE_LINE;
               nxt.mode_ticks        = '0;
               flags.regulator_reset = 1'b1;
            end else begin
               nxt.mode_ticks = tick_inc[oas_pkg::TICK_W-1:0];
            end
         end
         default: begin
            mode           = oas_pkg::MODE_LINE;
            nxt.mode_ticks = '0;
         end
      endcase

      nxt.mode = mode;
   end

endmodule

/* rtl/obstacle_avoid_sequencer.sv */
// ----------------------------------------------------------------------------
// obstacle_avoid_sequencer
// Per-tick obstacle avoidance sequence and wheel drive mix for a line follower.
// ----------------------------------------------------------------------------
// One req word is one control tick; it produces exactly one rsp word. The tick
// is evaluated combinationally between the held sequence state and the rsp
// register, so a new req word is taken every cycle as long as the rsp
// register is empty or being drained the same cycle. Registers are written
// through the csr channel, which is always ready; write them only while no
// tick is in flight.
// ----------------------------------------------------------------------------
module obstacle_avoid_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: distance_mm[11:0], speed_correction[21:12],
   //            turn_correction[30:22], zero[31]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [oas_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: motor_command[2:0], drive_level[12:3], left_level[22:13],
   //            right_level[32:23], mode[35:33], regulator_reset[36],
   //            regulator_used[37], zero[39:38]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [oas_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [oas_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [oas_pkg::CSR_DATA_W-1:0]    csr_data
);

   oas_pkg::cfg_type      cfg_ff, cfg_in;
   oas_pkg::state_type    state_ff, state_in;
   oas_pkg::state_type    step_state;
   oas_pkg::flags_type    step_flags;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [oas_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  req_take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   oas_step u_step (
      .cfg              (cfg_ff),
      .cur              (state_ff),
      .distance_mm      (req_tdata[11:0]),
      .speed_correction (req_tdata[21:12]),
      .turn_correction  ($signed(req_tdata[30:22])),
      .nxt              (step_state),
      .flags            (step_flags)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            oas_pkg::REG_DETECT_THRESHOLD: cfg_in.detect_threshold_mm = csr_data;
            oas_pkg::REG_SPIN_PWM:         cfg_in.spin_pwm           = csr_data[9:0];
            oas_pkg::REG_BYPASS_PWM:       cfg_in.bypass_pwm         = csr_data[9:0];
            oas_pkg::REG_STOP_TICKS:       cfg_in.stop_ticks         = csr_data[7:0];
            oas_pkg::REG_QUARTER_TICKS:    cfg_in.quarter_turn_ticks = csr_data[7:0];
            oas_pkg::REG_HALF_TICKS:       cfg_in.half_turn_ticks    = csr_data[7:0];
            oas_pkg::REG_BYPASS_TICKS:     cfg_in.bypass_ticks       = csr_data[7:0];
            oas_pkg::REG_TIMEOUT_TICKS:    cfg_in.timeout_ticks      = csr_data[8:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;
      if (req_take) begin
         state_in     = step_state;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00,
                         step_flags.regulator_used,
                         step_flags.regulator_reset,
                         oas_pkg::mode_number(step_state.mode),
                         step_state.held_right,
                         step_state.held_left,
                         step_state.held_drive,
                         step_state.held_command};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= oas_pkg::CFG_RESET;
         state_ff     <= oas_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* bench/tb_obstacle_avoid_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_obstacle_avoid_sequencer
// Self-checking bench for the obstacle avoidance sequencer. A short stimulus
// table walks the avoidance sequence, the timeout and the level clamps. Random
// phases follow, each with new register settings and segments of far, near
// and missing range readings. Every rsp word is compared field by field with
// its table row where one is typed, else with the bench's tick-level model.
// ----------------------------------------------------------------------------
module tb_obstacle_avoid_sequencer;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int TABLE_ROWS      = 25;
   localparam int ROW_B           = 5;   // first row after the short-tick setup
   localparam int ROW_C           = 21;  // first row after the timeout setup

   typedef struct packed {
      logic [oas_pkg::DIST_W-1:0]        range_mm;
      logic [oas_pkg::SPEED_W-1:0]       speed;
      logic signed [oas_pkg::TURN_W-1:0] turn;
   } tick_in_type;

   typedef struct packed {
      logic [oas_pkg::CMD_W-1:0]   cmd;
      logic [oas_pkg::LEVEL_W-1:0] drive;
      logic [oas_pkg::LEVEL_W-1:0] left_lvl;
      logic [oas_pkg::LEVEL_W-1:0] right_lvl;
      logic [oas_pkg::MODE_W-1:0]  mode;
      logic                        reg_reset;
      logic                        reg_used;
   } tick_out_type;

   typedef struct packed {
      logic         typed;
      tick_out_type want;
   } row_note_type;

   typedef struct packed {
      tick_in_type  stim;
      logic         typed;
      tick_out_type want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [oas_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [oas_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [oas_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [oas_pkg::CSR_DATA_W-1:0] csr_data = '0;

   obstacle_avoid_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sequence model state
   oas_pkg::cfg_type              regs = oas_pkg::CFG_RESET;
   logic [oas_pkg::MODE_W-1:0]    seq_mode = oas_pkg::MODE_NUM_LINE;
   logic [8:0]                    seq_ticks = '0;
   logic [9:0]                    seq_total = '0;
   logic [oas_pkg::CMD_W-1:0]     cmd_hold = oas_pkg::CMD_STOP;
   logic [oas_pkg::LEVEL_W-1:0]   drive_hold = '0;
   logic [oas_pkg::LEVEL_W-1:0]   left_hold = '0;
   logic [oas_pkg::LEVEL_W-1:0]   right_hold = '0;

   tick_out_type tick_outcomes[$];
   row_note_type row_overrides[$];
   int           errors = 0;
   int           cycles = 0;
   bit           no_idle = 1'b0;
   int           seg_kind = 0;
   int           seg_left = 0;

   const table_row_type stim_table [TABLE_ROWS] = '{
      // reset settings: wheel mix extremes, then an obstacle at the threshold
      '{'{12'd0,    10'd0,    9'sd0},   1'b1,
        '{oas_pkg::CMD_FORWARD, 10'd0, 10'd50,  10'd50,  oas_pkg::MODE_NUM_LINE,
          1'b0, 1'b1}},
      '{'{12'd4095, 10'd1023, 9'sd255}, 1'b1,
        '{oas_pkg::CMD_FORWARD, 10'd0, 10'd600, 10'd600, oas_pkg::MODE_NUM_LINE,
          1'b0, 1'b1}},
      '{'{12'd201,  10'd300,  9'h100},  1'b1,
        '{oas_pkg::CMD_FORWARD, 10'd0, 10'd50,  10'd556, oas_pkg::MODE_NUM_LINE,
          1'b0, 1'b1}},
      '{'{12'd300,  10'd49,   9'sd100}, 1'b1,
        '{oas_pkg::CMD_FORWARD, 10'd0, 10'd150, 10'd50,  oas_pkg::MODE_NUM_LINE,
          1'b0, 1'b1}},
      '{'{12'd200,  10'd512,  9'h1FF},  1'b1,
        '{oas_pkg::CMD_STOP,    10'd0, 10'd0,   10'd0,   oas_pkg::MODE_NUM_STOP,
          1'b1, 1'b0}},
      // one-tick stop and spins: left check sees no data, right blocked (dead end)
      '{'{12'd4095, 10'd100, 9'sd0},    1'b0, '0},
      '{'{12'd0,    10'd200, 9'sd10},   1'b0, '0},
      '{'{12'd0,    10'd200, 9'sd10},   1'b0, '0},
      '{'{12'd0,    10'd200, 9'sd10},   1'b0, '0},
      '{'{12'd0,    10'd200, 9'sd10},   1'b0, '0},
      '{'{12'd2048, 10'd333, -9'sd77},  1'b0, '0},
      '{'{12'd150,  10'd333, 9'sd0},    1'b0, '0},
      '{'{12'd150,  10'd333, 9'sd0},    1'b0, '0},
      '{'{12'd100,  10'd333, 9'sd0},    1'b0, '0},
      // again, left check clear, then a new obstacle while bypassing
      '{'{12'd50,   10'd300, -9'sd20},  1'b0, '0},
      '{'{12'd3000, 10'd300, 9'sd5},    1'b0, '0},
      '{'{12'd3000, 10'd300, 9'sd5},    1'b0, '0},
      '{'{12'd4095, 10'd300, 9'sd5},    1'b0, '0},
      '{'{12'd4095, 10'd300, 9'sd5},    1'b0, '0},
      '{'{12'd201,  10'd300, 9'sd5},    1'b0, '0},
      '{'{12'd199,  10'd300, 9'sd5},    1'b0, '0},
      // timeout lowered below the running count, zero stop ticks
      '{'{12'd1000, 10'd400, -9'sd30},  1'b0, '0},
      '{'{12'd1,    10'd250, 9'sd40},   1'b0, '0},
      '{'{12'd4095, 10'd250, 9'sd0},    1'b0, '0},
      '{'{12'd3000, 10'd600, 9'sd250},  1'b0, '0}
   };

   function automatic logic [oas_pkg::LEVEL_W-1:0] clamp_wheel(int v);
      if (v < int'(oas_pkg::WHEEL_MIN)) return oas_pkg::WHEEL_MIN;
      if (v > int'(oas_pkg::WHEEL_MAX)) return oas_pkg::WHEEL_MAX;
      return v[oas_pkg::LEVEL_W-1:0];
   endfunction

   // advance the sequence by one tick and return the rsp word it produces
   function automatic tick_out_type sequence_tick(tick_in_type t);
      tick_out_type o;
      logic seen, clear_ahead;
      logic signed [oas_pkg::TURN_W-1:0] steer;
      int base;
      o = '0;
      steer = t.turn;
      seen = (t.range_mm != '0) && (t.range_mm <= regs.detect_threshold_mm);
      clear_ahead = t.range_mm > regs.detect_threshold_mm;
      if (seq_mode != oas_pkg::MODE_NUM_LINE) begin
         seq_total = seq_total + 10'd1;
         if (seq_total >= {1'b0, regs.timeout_ticks}) begin
            // forced return; the line follow step still runs this tick
            seq_mode = oas_pkg::MODE_NUM_LINE;
            seq_ticks = '0;
            seq_total = '0;
            o.reg_reset = 1'b1;
            cmd_hold = oas_pkg::CMD_STOP;
            drive_hold = '0;
         end
      end
      case (seq_mode)
         oas_pkg::MODE_NUM_LINE: begin
            seq_total = '0;
            if (seen) begin
               seq_mode = oas_pkg::MODE_NUM_STOP;
               seq_ticks = '0;
               o.reg_reset = 1'b1;
               cmd_hold = oas_pkg::CMD_STOP;
               drive_hold = '0;
               left_hold = '0;
               right_hold = '0;
            end else begin
               base = (t.speed < oas_pkg::WHEEL_MIN) ? int'(oas_pkg::WHEEL_MIN)
                                                     : int'(t.speed);
               left_hold = clamp_wheel(base + int'(steer));
               right_hold = clamp_wheel(base - int'(steer));
               cmd_hold = oas_pkg::CMD_FORWARD;
               o.reg_used = 1'b1;
            end
         end
         oas_pkg::MODE_NUM_STOP: begin
            cmd_hold = oas_pkg::CMD_STOP;
            drive_hold = '0;
            seq_ticks = seq_ticks + 9'd1;
            if (seq_ticks >= {1'b0, regs.stop_ticks}) begin
               seq_mode = oas_pkg::MODE_NUM_SPIN_L;
               seq_ticks = '0;
            end
         end
         oas_pkg::MODE_NUM_SPIN_L: begin
            cmd_hold = oas_pkg::CMD_SPIN_LEFT;
            drive_hold = regs.spin_pwm;
            seq_ticks = seq_ticks + 9'd1;
            if (seq_ticks >= {1'b0, regs.quarter_turn_ticks}) begin
               seq_mode = oas_pkg::MODE_NUM_CHECK_L;
               seq_ticks = '0;
               cmd_hold = oas_pkg::CMD_STOP;
               drive_hold = '0;
            end
         end
         oas_pkg::MODE_NUM_CHECK_L: begin
            cmd_hold = oas_pkg::CMD_STOP;
            drive_hold = '0;
            seq_ticks = seq_ticks + 9'd1;
            if (seq_ticks >= {1'b0, oas_pkg::CHECK_TICKS}) begin
               seq_mode = clear_ahead ? oas_pkg::MODE_NUM_BYPASS : oas_pkg::MODE_NUM_SPIN_R;
               seq_ticks = '0;
            end
         end
         oas_pkg::MODE_NUM_SPIN_R: begin
            cmd_hold = oas_pkg::CMD_SPIN_RIGHT;
            drive_hold = regs.spin_pwm;
            seq_ticks = seq_ticks + 9'd1;
            if (seq_ticks >= {1'b0, regs.half_turn_ticks}) begin
               seq_mode = oas_pkg::MODE_NUM_CHECK_R;
               seq_ticks = '0;
               cmd_hold = oas_pkg::CMD_STOP;
               drive_hold = '0;
            end
         end
         oas_pkg::MODE_NUM_CHECK_R: begin
            cmd_hold = oas_pkg::CMD_STOP;
            drive_hold = '0;
            seq_ticks = seq_ticks + 9'd1;
            // blocked both ways: give up without clearing the regulators
            if (seq_ticks >= {1'b0, oas_pkg::CHECK_TICKS}) begin
               seq_mode = clear_ahead ? oas_pkg::MODE_NUM_BYPASS : oas_pkg::MODE_NUM_LINE;
               seq_ticks = '0;
            end
         end
         default: begin
            cmd_hold = oas_pkg::CMD_FORWARD;
            drive_hold = regs.bypass_pwm;
            seq_ticks = seq_ticks + 9'd1;
            if (seen) begin
               seq_mode = oas_pkg::MODE_NUM_STOP;
               seq_ticks = '0;
            end else if (seq_ticks >= {1'b0, regs.bypass_ticks}) begin
               seq_mode = oas_pkg::MODE_NUM_LINE;
               seq_ticks = '0;
               o.reg_reset = 1'b1;
            end
         end
      endcase
      o.cmd = cmd_hold;
      o.drive = drive_hold;
      o.left_lvl = left_hold;
      o.right_lvl = right_hold;
      o.mode = seq_mode;
      return o;
   endfunction

   task automatic report_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      end
   endtask

   task automatic apply_reg(logic [oas_pkg::CSR_IDX_W-1:0] idx,
                            logic [oas_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         oas_pkg::REG_DETECT_THRESHOLD: regs.detect_threshold_mm = val;
         oas_pkg::REG_SPIN_PWM:         regs.spin_pwm = val[oas_pkg::LEVEL_W-1:0];
         oas_pkg::REG_BYPASS_PWM:       regs.bypass_pwm = val[oas_pkg::LEVEL_W-1:0];
         oas_pkg::REG_STOP_TICKS:       regs.stop_ticks = val[oas_pkg::TICK_W-1:0];
         oas_pkg::REG_QUARTER_TICKS:    regs.quarter_turn_ticks = val[oas_pkg::TICK_W-1:0];
         oas_pkg::REG_HALF_TICKS:       regs.half_turn_ticks = val[oas_pkg::TICK_W-1:0];
         oas_pkg::REG_BYPASS_TICKS:     regs.bypass_ticks = val[oas_pkg::TICK_W-1:0];
         oas_pkg::REG_TIMEOUT_TICKS:    regs.timeout_ticks = val[oas_pkg::TOTAL_W-1:0];
         default: ;
      endcase
   endtask

   // monitor: check rsp words, model accepted req words, track csr writes
   always @(posedge clock) begin
      tick_out_type want;
      row_note_type note;
      tick_in_type  t;
      tick_out_type modeled;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (tick_outcomes.size() == 0) begin
               errors++;
               $display("%0t: rsp word with none expected, expected none got %h",
                        $time, rsp_tdata);
            end else begin
               want = tick_outcomes.pop_front();
               report_field("motor_command",   int'(want.cmd),       int'(rsp_tdata[2:0]));
               report_field("drive_level",     int'(want.drive),     int'(rsp_tdata[12:3]));
               report_field("left_level",      int'(want.left_lvl),  int'(rsp_tdata[22:13]));
               report_field("right_level",     int'(want.right_lvl), int'(rsp_tdata[32:23]));
               report_field("mode",            int'(want.mode),      int'(rsp_tdata[35:33]));
               report_field("regulator_reset", int'(want.reg_reset), int'(rsp_tdata[36]));
               report_field("regulator_used",  int'(want.reg_used),  int'(rsp_tdata[37]));
            end
         end
         if (req_tvalid && req_tready) begin
            t.range_mm = req_tdata[11:0];
            t.speed = req_tdata[21:12];
            t.turn = req_tdata[30:22];
            modeled = sequence_tick(t);
            note = row_overrides.pop_front();
            tick_outcomes.push_back(note.typed ? note.want : modeled);
         end
         if (csr_valid && csr_ready)
            apply_reg(csr_index, csr_data);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_ticks();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 6);
      if (r < 90) return 0;
      return $urandom_range(7, 255);
   endfunction

   // rsp back-pressure
   initial begin : rsp_sink
      int g;
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         g = no_idle ? 0 : pick_gap();
         if (g != 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

   task automatic send_tick(tick_in_type t, logic typed, tick_out_type want);
      int gap;
      row_note_type note_w;
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note_w.typed = typed;
      note_w.want = want;
      row_overrides.push_back(note_w);
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, t.turn, t.speed, t.range_mm};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and hold off until every rsp word is back
   task automatic drain_ticks();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tick_outcomes.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [oas_pkg::CSR_IDX_W-1:0] idx, int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[oas_pkg::CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(int thr, int spin, int byp, int stop_t, int quarter_t,
                               int half_t, int byp_t, int tmo);
      write_reg(oas_pkg::REG_DETECT_THRESHOLD, thr);
      write_reg(oas_pkg::REG_SPIN_PWM, spin);
      write_reg(oas_pkg::REG_BYPASS_PWM, byp);
      write_reg(oas_pkg::REG_STOP_TICKS, stop_t);
      write_reg(oas_pkg::REG_QUARTER_TICKS, quarter_t);
      write_reg(oas_pkg::REG_HALF_TICKS, half_t);
      write_reg(oas_pkg::REG_BYPASS_TICKS, byp_t);
      write_reg(oas_pkg::REG_TIMEOUT_TICKS, tmo);
      csr_valid <= 1'b0;
   endtask

   // readings come in segments so that whole avoidance runs complete
   function automatic tick_in_type next_tick();
      tick_in_type t;
      int thr, tv, r;
      if (seg_left == 0) begin
         seg_kind = $urandom_range(0, 9);
         seg_left = $urandom_range(1, 16);
      end
      seg_left--;
      thr = int'(regs.detect_threshold_mm);
      if (seg_kind <= 4 && thr < 4095)
         r = $urandom_range(thr + 1, 4095);
      else if (seg_kind <= 6 && thr != 0)
         r = $urandom_range(1, thr);
      else if (seg_kind == 7)
         r = 0;
      else
         r = $urandom_range(0, 4095);
      t.range_mm = r[oas_pkg::DIST_W-1:0];
      r = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 600) : $urandom_range(0, 1023);
      t.speed = r[oas_pkg::SPEED_W-1:0];
      if ($urandom_range(0, 99) < 85)
         tv = int'($urandom_range(0, 500)) - 250;
      else
         tv = int'($urandom_range(0, 511)) - 256;
      t.turn = tv[oas_pkg::TURN_W-1:0];
      return t;
   endfunction

   initial begin
      int p, i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < TABLE_ROWS; i++) begin
         if (i == ROW_B) begin
            drain_ticks();
            program_regs(200, 700, 250, 1, 1, 1, 2, 511);
         end else if (i == ROW_C) begin
            drain_ticks();
            program_regs(200, 700, 250, 0, 1, 1, 2, 2);
         end
         send_tick(stim_table[i].stim, stim_table[i].typed, stim_table[i].want);
      end

      for (p = 0; p < PHASES; p++) begin
         drain_ticks();
         if (p == 0)
            program_regs(4095, 1023, 1023, 255, 255, 255, 255, 511);
         else if (p == 1)
            program_regs(1, 0, 0, 0, 0, 0, 0, 0);
         else
            program_regs(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(100, 1500),
                         $urandom_range(0, 1023), $urandom_range(0, 1023),
                         pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20)
                                                     : $urandom_range(30, 511));
         no_idle = ($urandom_range(0, 3) == 0);
         seg_left = 0;
         for (i = 0; i < ITEMS_PER_PHASE; i++)
            send_tick(next_tick(), 1'b0, '0);
      end

      drain_ticks();
      if (errors == 0 && tick_outcomes.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/oas_pkg.sv
rtl/oas_step.sv
rtl/obstacle_avoid_sequencer.sv
bench/tb_obstacle_avoid_sequencer.sv
